FILE: rtl/parallel_port_interface_adapter_unit_assert.svh
// Assertion helpers for the adapter unit.
`ifndef PARALLEL_PORT_INTERFACE_ADAPTER_UNIT_ASSERT_SVH
`define PARALLEL_PORT_INTERFACE_ADAPTER_UNIT_ASSERT_SVH

// Consequent holds in the same cycle as the antecedent.
`define PPIAU_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("ppiau same-cycle check failed");

// Consequent holds in the cycle after the antecedent.
`define PPIAU_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("ppiau next-cycle check failed");

`endif

FILE: rtl/ppiau_pkg.sv
`timescale 1ns / 1ps

package ppiau_pkg;

    localparam int unsigned MODE_W   = 3;
    localparam int unsigned OFFSET_W = 2;
    localparam int unsigned DATA_W   = 8;
    localparam int unsigned CTRL_W   = 6;
    localparam int unsigned APB_AW   = 3;
    localparam int unsigned APB_DW   = 32;

    // Control register bit positions
    localparam int unsigned CTL_C1_IRQ_EN = 0;
    localparam int unsigned CTL_C1_RISE   = 1;
    localparam int unsigned CTL_DATA_SEL  = 2;
    localparam int unsigned CTL_C2_BIT3   = 3;
    localparam int unsigned CTL_C2_BIT4   = 4;
    localparam int unsigned CTL_C2_OUT    = 5;

    // Configuration register indexes
    localparam logic [0:0] CFG_ALT_ORDER = 1'b0;

    typedef enum logic [MODE_W-1:0] {
        MODE_READ  = 3'd0,
        MODE_WRITE = 3'd1,
        MODE_PINSA = 3'd2,
        MODE_PINSB = 3'd3,
        MODE_CA1   = 3'd4,
        MODE_CA2   = 3'd5,
        MODE_CB1   = 3'd6,
        MODE_CB2   = 3'd7
    } t_mode;

    typedef enum logic [OFFSET_W-1:0] {
        REG_PORT_A = 2'd0,
        REG_CTRL_A = 2'd1,
        REG_PORT_B = 2'd2,
        REG_CTRL_B = 2'd3
    } t_reg_sel;

    typedef struct packed {
        logic [DATA_W-1:0] read_data;
        logic              irq_a;
        logic              irq_b;
        logic [DATA_W-1:0] port_a_drive;
        logic [DATA_W-1:0] port_b_drive;
        logic              port_a_update;
        logic              port_b_update;
        logic              ca2_level;
        logic              cb2_level;
        logic              ca2_pulse;
        logic              cb2_pulse;
    } t_result;

    // Alternate ordering swaps offsets 1 and 2.
    function automatic t_reg_sel f_decode_offset(input logic [OFFSET_W-1:0] off,
                                                 input logic alt);
        logic [OFFSET_W-1:0] sel;
        sel = alt ? {off[0], off[1]} : off;
        return t_reg_sel'(sel);
    endfunction

endpackage

FILE: rtl/ppiau_if.sv
`timescale 1ns / 1ps

interface ppiau_in_if;
    import ppiau_pkg::*;

    logic              valid;
    logic              ready;
    logic [MODE_W-1:0]   mode;
    logic [OFFSET_W-1:0] reg_offset;
    logic [DATA_W-1:0]   data_value;

    modport source (output valid, mode, reg_offset, data_value, input ready);
    modport sink   (input valid, mode, reg_offset, data_value, output ready);
endinterface

interface ppiau_out_if;
    import ppiau_pkg::*;

    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] read_data;
    logic              irq_a;
    logic              irq_b;
    logic [DATA_W-1:0] port_a_drive;
    logic [DATA_W-1:0] port_b_drive;
    logic              port_a_update;
    logic              port_b_update;
    logic              ca2_level;
    logic              cb2_level;
    logic              ca2_pulse;
    logic              cb2_pulse;

    modport source (output valid, read_data, irq_a, irq_b, port_a_drive, port_b_drive,
                    port_a_update, port_b_update, ca2_level, cb2_level, ca2_pulse,
                    cb2_pulse, input ready);
    modport sink   (input valid, read_data, irq_a, irq_b, port_a_drive, port_b_drive,
                    port_a_update, port_b_update, ca2_level, cb2_level, ca2_pulse,
                    cb2_pulse, output ready);
endinterface

FILE: rtl/parallel_port_interface_adapter_unit.sv
`timescale 1ns / 1ps
// Channel   | Direction | Beat contents
// ----------+-----------+-----------------------------------------------
// i_in      | sink      | mode, reg_offset, data_value
// o_out     | source    | read_data, irq_a/b, port_a/b_drive, port_a/b_update,
//           |           | ca2/cb2_level, ca2/cb2_pulse
// APB       | slave     | register 0 (alternate_ordering) at byte address 0
//
// One beat in, one beat out; every input beat is handled in combinational logic
// between the unit's state registers and the result register, so a beat can be
// taken on every clock unless held off. The result lands in an output register
// backed by a single skid entry; input ready drops only while it is full.
// Synchronous active-low reset clears all port, control and flag state.

module parallel_port_interface_adapter_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    ppiau_in_if.sink                      i_in,
    ppiau_out_if.source                   o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ppiau_pkg::APB_AW-1:0]  paddr,
    input  logic [ppiau_pkg::APB_DW-1:0]  pwdata,
    output logic [ppiau_pkg::APB_DW-1:0]  prdata,
    output logic                          pready
);
    import ppiau_pkg::*;

    // Configuration
    logic r_alt;

    // Port state
    logic [DATA_W-1:0] r_pins_a, r_pins_b, r_out_a, r_out_b, r_dir_a, r_dir_b;
    logic [DATA_W-1:0] n_pins_a, n_pins_b, n_out_a, n_out_b, n_dir_a, n_dir_b;
    logic [CTRL_W-1:0] r_ctl_a, r_ctl_b, n_ctl_a, n_ctl_b;
    logic [3:0]        r_lvl, n_lvl;      // CA1 CA2 CB1 CB2 input levels
    logic [3:0]        r_flags, n_flags;  // A1 A2 B1 B2 edge flags
    logic [1:0]        r_c2, n_c2;        // CA2, CB2 output levels

    // Result register and skid entry
    t_result r_res, r_skid, n_res;
    logic    r_res_v, r_skid_v;

    logic     in_acc, out_fire, cfg_wr, lvl;
    t_mode    mode;
    t_reg_sel sel;
    logic [DATA_W-1:0] d;

    // -------------------------------------------------------------------
    // Configuration port: zero wait states, index taken from paddr[2]
    // -------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        prdata = '0;
        if (paddr[2] == CFG_ALT_ORDER) begin
            prdata[0] = r_alt;
        end
    end

    // -------------------------------------------------------------------
    // Handshake: hold off input only while the skid entry is occupied
    // -------------------------------------------------------------------
    assign i_in.ready = !r_skid_v;
    assign in_acc     = i_in.valid && i_in.ready;
    assign out_fire   = r_res_v && o_out.ready;

    assign mode = t_mode'(i_in.mode);
    assign sel  = f_decode_offset(i_in.reg_offset, r_alt);
    assign d    = i_in.data_value;
    assign lvl  = |i_in.data_value;

    // -------------------------------------------------------------------
    // Next-state logic for one beat
    // -------------------------------------------------------------------
    always_comb begin
        n_pins_a = r_pins_a;
        n_pins_b = r_pins_b;
        n_out_a  = r_out_a;
        n_out_b  = r_out_b;
        n_dir_a  = r_dir_a;
        n_dir_b  = r_dir_b;
        n_ctl_a  = r_ctl_a;
        n_ctl_b  = r_ctl_b;
        n_lvl    = r_lvl;
        n_flags  = r_flags;
        n_c2     = r_c2;
        n_res    = '0;

        unique case (mode)
            MODE_READ: begin
                unique case (sel)
                    REG_PORT_A: begin
                        if (r_ctl_a[CTL_DATA_SEL]) begin
                            n_res.read_data = (r_out_a & r_dir_a) | (r_pins_a & ~r_dir_a);
                            n_flags[1:0]    = 2'b00;
                            // Strobe CA2 low; restore at once when enabled
                            if (r_ctl_a[CTL_C2_OUT] && !r_ctl_a[CTL_C2_BIT4]) begin
                                n_c2[0]         = r_ctl_a[CTL_C2_BIT3];
                                n_res.ca2_pulse = r_ctl_a[CTL_C2_BIT3];
                            end
                        end else begin
                            n_res.read_data = r_dir_a;
                        end
                    end
                    REG_PORT_B: begin
                        if (r_ctl_b[CTL_DATA_SEL]) begin
                            n_res.read_data = (r_out_b & r_dir_b) | (r_pins_b & ~r_dir_b);
                            n_flags[3:2]    = 2'b00;
                        end else begin
                            n_res.read_data = r_dir_b;
                        end
                    end
                    REG_CTRL_A: begin
                        n_res.read_data = {r_flags[0], r_flags[1] && !r_ctl_a[CTL_C2_OUT],
                                           r_ctl_a};
                    end
                    default: begin
                        n_res.read_data = {r_flags[2], r_flags[3] && !r_ctl_b[CTL_C2_OUT],
                                           r_ctl_b};
                    end
                endcase
            end
            MODE_WRITE: begin
                unique case (sel)
                    REG_PORT_A: begin
                        if (r_ctl_a[CTL_DATA_SEL]) begin
                            n_out_a             = d;
                            n_res.port_a_update = |r_dir_a;
                        end else if (r_dir_a != d) begin
                            n_dir_a             = d;
                            n_res.port_a_update = |d;
                        end
                    end
                    REG_PORT_B: begin
                        if (r_ctl_b[CTL_DATA_SEL]) begin
                            n_out_b             = d;
                            n_res.port_b_update = |r_dir_b;
                            if (r_ctl_b[CTL_C2_OUT] && !r_ctl_b[CTL_C2_BIT4]) begin
                                n_c2[1]         = r_ctl_b[CTL_C2_BIT3];
                                n_res.cb2_pulse = r_ctl_b[CTL_C2_BIT3];
                            end
                        end else if (r_dir_b != d) begin
                            n_dir_b             = d;
                            n_res.port_b_update = |d;
                        end
                    end
                    REG_CTRL_A: begin
                        // Drop the two flag bits; an output C2 follows bit 3
                        n_ctl_a = d[CTRL_W-1:0];
                        if (d[CTL_C2_OUT]) begin
                            n_c2[0] = d[CTL_C2_BIT3];
                        end
                    end
                    default: begin
                        n_ctl_b = d[CTRL_W-1:0];
                        if (d[CTL_C2_OUT]) begin
                            n_c2[1] = d[CTL_C2_BIT3];
                        end
                    end
                endcase
            end
            MODE_PINSA: n_pins_a = d;
            MODE_PINSB: n_pins_b = d;
            MODE_CA1: begin
                if (r_lvl[0] != lvl && lvl == r_ctl_a[CTL_C1_RISE]) begin
                    n_flags[0] = 1'b1;
                    // Restore CA2 in strobe mode with restore by CA1
                    if (r_ctl_a[CTL_C2_OUT] && !r_ctl_a[CTL_C2_BIT4]
                        && !r_ctl_a[CTL_C2_BIT3]) begin
                        n_c2[0] = 1'b1;
                    end
                end
                n_lvl[0] = lvl;
            end
            MODE_CA2: begin
                if (!r_ctl_a[CTL_C2_OUT] && r_lvl[1] != lvl
                    && lvl == r_ctl_a[CTL_C2_BIT4]) begin
                    n_flags[1] = 1'b1;
                end
                n_lvl[1] = lvl;
            end
            MODE_CB1: begin
                // CB1 flags only; CB2 is never restored from here
                if (r_lvl[2] != lvl && lvl == r_ctl_b[CTL_C1_RISE]) begin
                    n_flags[2] = 1'b1;
                end
                n_lvl[2] = lvl;
            end
            default: begin
                if (!r_ctl_b[CTL_C2_OUT] && r_lvl[3] != lvl
                    && lvl == r_ctl_b[CTL_C2_BIT4]) begin
                    n_flags[3] = 1'b1;
                end
                n_lvl[3] = lvl;
            end
        endcase

        // Status after the beat
        n_res.irq_a = (n_flags[0] && n_ctl_a[CTL_C1_IRQ_EN])
                    || (n_flags[1] && n_ctl_a[CTL_C2_BIT3]);
        n_res.irq_b = (n_flags[2] && n_ctl_b[CTL_C1_IRQ_EN])
                    || (n_flags[3] && n_ctl_b[CTL_C2_BIT3]);
        n_res.port_a_drive = n_out_a & n_dir_a;
        n_res.port_b_drive = n_out_b & n_dir_b;
        n_res.ca2_level    = n_c2[0];
        n_res.cb2_level    = n_c2[1];
    end

    // -------------------------------------------------------------------
    // State registers
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_alt    <= 1'b0;
            r_pins_a <= '0;
            r_pins_b <= '0;
            r_out_a  <= '0;
            r_out_b  <= '0;
            r_dir_a  <= '0;
            r_dir_b  <= '0;
            r_ctl_a  <= '0;
            r_ctl_b  <= '0;
            r_lvl    <= '0;
            r_flags  <= '0;
            r_c2     <= '0;
        end else begin
            if (cfg_wr && paddr[2] == CFG_ALT_ORDER) begin
                r_alt <= pwdata[0];
            end
            if (in_acc) begin
                r_pins_a <= n_pins_a;
                r_pins_b <= n_pins_b;
                r_out_a  <= n_out_a;
                r_out_b  <= n_out_b;
                r_dir_a  <= n_dir_a;
                r_dir_b  <= n_dir_b;
                r_ctl_a  <= n_ctl_a;
                r_ctl_b  <= n_ctl_b;
                r_lvl    <= n_lvl;
                r_flags  <= n_flags;
                r_c2     <= n_c2;
            end
        end
    end

    // -------------------------------------------------------------------
    // Result register with skid entry: advance skid when the head is taken
    // -------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else begin
            if (out_fire || !r_res_v) begin
                if (r_skid_v) begin
                    r_res_v  <= 1'b1;
                    r_skid_v <= in_acc;
                end else begin
                    r_res_v <= in_acc;
                end
            end else if (in_acc) begin
                r_skid_v <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_fire || !r_res_v) begin
            if (r_skid_v) begin
                r_res <= r_skid;
                if (in_acc) begin
                    r_skid <= n_res;
                end
            end else if (in_acc) begin
                r_res <= n_res;
            end
        end else if (in_acc) begin
            r_skid <= n_res;
        end
    end

    assign o_out.valid         = r_res_v;
    assign o_out.read_data     = r_res.read_data;
    assign o_out.irq_a         = r_res.irq_a;
    assign o_out.irq_b         = r_res.irq_b;
    assign o_out.port_a_drive  = r_res.port_a_drive;
    assign o_out.port_b_drive  = r_res.port_b_drive;
    assign o_out.port_a_update = r_res.port_a_update;
    assign o_out.port_b_update = r_res.port_b_update;
    assign o_out.ca2_level     = r_res.ca2_level;
    assign o_out.cb2_level     = r_res.cb2_level;
    assign o_out.ca2_pulse     = r_res.ca2_pulse;
    assign o_out.cb2_pulse     = r_res.cb2_pulse;

    // -------------------------------------------------------------------
    // Assertions
    // -------------------------------------------------------------------
`include "parallel_port_interface_adapter_unit_assert.svh"

    `PPIAU_ASSERT_SAME(a_skid_behind_head, i_clk, i_rst_n, r_skid_v, r_res_v)
    `PPIAU_ASSERT_NEXT(a_stall_fills_skid, i_clk, i_rst_n, r_res_v && !o_out.ready && in_acc, r_skid_v)
    `PPIAU_ASSERT_SAME(a_ca2_pulse_restored, i_clk, i_rst_n, r_res_v && r_res.ca2_pulse, r_res.ca2_level)
    `PPIAU_ASSERT_SAME(a_cb2_pulse_restored, i_clk, i_rst_n, r_res_v && r_res.cb2_pulse, r_res.cb2_level)

endmodule
